// ===== rtl/core/edfs_pkg.sv =====
// Shared types and constants of the EDF task scheduler.
// Used by edfs_entry_eval and edf_task_scheduler; no dependencies.
package edfs_pkg;

  localparam int DEFAULT_MAX_TASKS = 8;

  localparam int TASK_INDEX_W = 3;
  localparam int WORK_W       = 16;
  localparam int TIME_W       = 32;
  localparam int COUNT_W      = 8;
  localparam int ACTIVE_W     = 4;
  localparam int MASK_W       = 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int S_TDATA_W    = 56;
  localparam int M_TDATA_W    = 56;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_TASKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HORIZON      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPLETIONS  = 2'd2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET      = 4'd1;
  localparam logic [TIME_W-1:0]   HORIZON_RESET     = 32'd0;
  localparam logic [COUNT_W-1:0]  COMPLETIONS_RESET = 8'd2;
  localparam logic [COUNT_W-1:0]  COUNT_LIMIT       = 8'd255;

  typedef struct packed {
    logic [WORK_W-1:0]  budget;
    logic [WORK_W-1:0]  remaining;
    logic [TIME_W-1:0]  deadline;
    logic [WORK_W-1:0]  period;
    logic [COUNT_W-1:0] completions;
  } entry_t;

  typedef struct packed {
    logic ready;
    logic enough;
  } scan_t;

  typedef struct packed {
    entry_t entry;
    logic   renew;
    logic   missed;
  } upd_t;

endpackage

// ===== rtl/core/edfs_entry_eval.sv =====
// Per-entry evaluation of one task record: readiness and stop test for the
// selection pass, renewal and write-back value for the update pass. Uses edfs_pkg.
module edfs_entry_eval import edfs_pkg::*; (
  input  entry_t             entry,
  input  logic [TIME_W-1:0]  clock_time,
  input  logic [COUNT_W-1:0] completions_to_stop,
  input  logic               run_hit,
  output scan_t              scan,
  output upd_t               upd
);

  logic [WORK_W-1:0] left;
  logic [TIME_W-1:0] clock_new;

  always_comb begin
    // clock + 1 <= deadline
    scan.ready  = (entry.remaining != '0) && (clock_time < entry.deadline);
    scan.enough = entry.completions >= completions_to_stop;

    left      = entry.remaining - WORK_W'(run_hit);
    clock_new = clock_time + TIME_W'(1);

    upd.entry           = entry;
    upd.entry.remaining = left;
    upd.renew           = clock_new >= entry.deadline;
    upd.missed          = upd.renew && (left != '0);
    if (upd.renew) begin
      if ((left == '0) && (entry.completions != COUNT_LIMIT)) begin
        upd.entry.completions = entry.completions + COUNT_W'(1);
      end
      upd.entry.deadline  = entry.deadline + TIME_W'(entry.period);
      upd.entry.remaining = entry.budget;
    end
  end

endmodule

// ===== rtl/core/edf_task_scheduler.sv =====
// EDF task scheduler top level: task table memory, scan sequencer, config
// registers and output register. Uses edfs_pkg and edfs_entry_eval.
// A load, or a tick after the stop, goes from idle straight to the done state; a tick that sets
// the stop sweeps the n live entries once to select, a running tick once to select and once to
// renew, one table read per cycle. Input is accepted only in idle, so items never overlap.
// Reset clears clock, stop flag, config and handshakes; table entries undefined until loaded.
module edf_task_scheduler import edfs_pkg::*; #(
  parameter int MAX_TASKS = DEFAULT_MAX_TASKS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // task_index[2:0], exec_time[18:3], first_deadline[34:19], task_period[50:35]
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // command[0]
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // ran_task[2:0], time_now[34:3], missed_mask[42:35], renewed_mask[50:43],
  // finished[51]
  output logic [M_TDATA_W-1:0]   m_tdata,
  // ran_valid[0]
  output logic                   m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state;

  logic [ACTIVE_W-1:0] active_tasks;
  logic [TIME_W-1:0]   horizon;
  logic [COUNT_W-1:0]  completions_to_stop;
  logic [TIME_W-1:0]   clock_time;
  logic                stopped;

  logic [CNT_W-1:0]    issue_cnt;
  logic                pend;
  logic [IDX_W-1:0]    pend_idx;
  logic                all_done;
  logic                found;
  logic [IDX_W-1:0]    best_idx;
  logic [TIME_W-1:0]   best_deadline;
  logic                res_ran_valid;
  logic [2:0]          res_ran_task;
  logic [MASK_W-1:0]   missed;
  logic [MASK_W-1:0]   renewed;

  entry_t              table_mem [MAX_TASKS];
  entry_t              rdata;
  entry_t              wdata;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [IDX_W-1:0]    raddr;
  logic                issue_go;

  logic [CNT_W-1:0]    live_n;
  logic                accept;
  logic                load_ok;
  logic [IDX_W+2:0]    load_ext;
  logic [IDX_W+2:0]    pend_ext;
  logic [IDX_W+2:0]    best_ext;
  logic [MASK_W-1:0]   pend_bit;
  logic                sweeping;
  logic                sweep_end;
  logic                out_free;
  logic                run_hit;
  scan_t               scan;
  upd_t                upd;
  entry_t              load_entry;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign live_n = (int'(active_tasks) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(active_tasks);

  assign load_ext = {{IDX_W{1'b0}}, s_tdata[2:0]};
  assign load_ok  = int'(s_tdata[2:0]) < MAX_TASKS;
  assign pend_ext = {3'b000, pend_idx};
  assign best_ext = {3'b000, best_idx};
  assign pend_bit = (int'(pend_ext) < MASK_W) ? (MASK_W'(1) << pend_ext[2:0]) : '0;

  assign sweeping  = (state == ST_SCAN) || (state == ST_UPDATE);
  assign issue_go  = sweeping && (issue_cnt != live_n);
  assign sweep_end = sweeping && (issue_cnt == live_n) && !pend;
  assign raddr     = issue_cnt[IDX_W-1:0];
  assign run_hit   = found && (pend_idx == best_idx);

  always_comb begin
    load_entry.budget      = s_tdata[18:3];
    load_entry.remaining   = s_tdata[18:3];
    load_entry.deadline    = TIME_W'(s_tdata[34:19]);
    load_entry.period      = s_tdata[50:35];
    load_entry.completions = '0;
  end

  edfs_entry_eval u_eval (
    .entry               (rdata),
    .clock_time          (clock_time),
    .completions_to_stop (completions_to_stop),
    .run_hit             (run_hit),
    .scan                (scan),
    .upd                 (upd)
  );

  // Update pass writes entry k while reading k+1, so no two accesses share an entry.
  always_comb begin
    we    = 1'b0;
    waddr = pend_idx;
    wdata = upd.entry;
    if (accept && (s_tuser == CMD_LOAD) && load_ok) begin
      we    = 1'b1;
      waddr = load_ext[IDX_W-1:0];
      wdata = load_entry;
    end else if ((state == ST_UPDATE) && pend) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    if (issue_go) begin
      rdata <= table_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_tasks        <= ACTIVE_RESET;
      horizon             <= HORIZON_RESET;
      completions_to_stop <= COMPLETIONS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACTIVE_TASKS: active_tasks        <= cfg_data[ACTIVE_W-1:0];
        REG_HORIZON:      horizon             <= cfg_data[TIME_W-1:0];
        REG_COMPLETIONS:  completions_to_stop <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      clock_time <= '0;
      stopped    <= 1'b0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (sweeping) begin
        if (issue_go) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
          pend_idx  <= raddr;
        end
        pend <= issue_go;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            issue_cnt     <= '0;
            pend          <= 1'b0;
            all_done      <= 1'b1;
            found         <= 1'b0;
            res_ran_valid <= 1'b0;
            res_ran_task  <= '0;
            missed        <= '0;
            renewed       <= '0;
            if ((s_tuser == CMD_TICK) && !stopped) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (pend) begin
            if (!scan.enough) begin
              all_done <= 1'b0;
            end
            if (scan.ready && (!found || (rdata.deadline < best_deadline))) begin
              found         <= 1'b1;
              best_idx      <= pend_idx;
              best_deadline <= rdata.deadline;
            end
          end
          if (sweep_end) begin
            if ((clock_time >= horizon) || all_done) begin
              stopped <= 1'b1;
              state   <= ST_DONE;
            end else begin
              issue_cnt     <= '0;
              res_ran_valid <= found;
              res_ran_task  <= found ? best_ext[2:0] : 3'd0;
              state         <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          if (pend) begin
            if (upd.renew) begin
              renewed <= renewed | pend_bit;
            end
            if (upd.missed) begin
              missed <= missed | pend_bit;
            end
          end
          if (sweep_end) begin
            clock_time <= clock_time + TIME_W'(1);
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_ran_valid;
            m_tdata  <= {4'b0000, stopped, renewed, missed, clock_time, res_ran_task};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_UPDATE) && pend && issue_go) |-> (pend_idx != raddr))
    else $error("update write collides with the next table read");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  a_ran_not_finished: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> !m_tdata[51])
    else $error("a task ran in a tick that reports finished");

  a_missed_in_renewed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[42:35] & ~m_tdata[50:43]) == '0))
    else $error("missed task not flagged as renewed");

  a_clock_moves_in_update: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && (clock_time != $past(clock_time))) |-> ($past(state) == ST_UPDATE))
    else $error("clock advanced outside the update pass");

endmodule

// ===== sim/edf_task_scheduler_tb.sv =====
// Self-checking testbench for edf_task_scheduler: random stream traffic on both sides,
// with an in-bench EDF predictor checking every result transfer field by field.
// Depends on edfs_pkg and the edf_task_scheduler RTL.
module edf_task_scheduler_tb import edfs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned PHASES    = 5;

  typedef struct {
    logic                 cmd;
    logic [S_TDATA_W-1:0] data;
  } sched_item_t;

  typedef struct packed {
    logic                    ran;
    logic [TASK_INDEX_W-1:0] who;
    logic [TIME_W-1:0]       now;
    logic [MASK_W-1:0]       missed;
    logic [MASK_W-1:0]       renewed;
    logic                    fin;
  } sched_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = CMD_LOAD;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_ACTIVE_TASKS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  edf_task_scheduler dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the task table and scheduler state
  logic [WORK_W-1:0]  t_budget [DEFAULT_MAX_TASKS];
  logic [WORK_W-1:0]  t_left   [DEFAULT_MAX_TASKS];
  logic [TIME_W-1:0]  t_due    [DEFAULT_MAX_TASKS];
  logic [WORK_W-1:0]  t_every  [DEFAULT_MAX_TASKS];
  logic [COUNT_W-1:0] t_done   [DEFAULT_MAX_TASKS];
  logic [TIME_W-1:0]  sched_clock = '0;
  logic               sched_halted = 1'b0;
  logic [ACTIVE_W-1:0] cfg_active  = ACTIVE_RESET;
  logic [TIME_W-1:0]   cfg_horizon = HORIZON_RESET;
  logic [COUNT_W-1:0]  cfg_need    = COMPLETIONS_RESET;

  sched_item_t item_q[$];
  sched_out_t  predicted_q[$];
  logic        s_fire = 1'b0;
  logic        quiet = 1'b0;
  logic        hold_out = 1'b0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned ran_cnt = 0;
  int unsigned miss_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;

  function automatic sched_out_t edf_step(logic cmd, logic [S_TDATA_W-1:0] d);
    sched_out_t              r;
    int unsigned             live;
    int unsigned             best;
    logic                    found;
    logic                    all_done;
    logic [TASK_INDEX_W-1:0] slot;
    r = '0;
    live = (cfg_active > DEFAULT_MAX_TASKS) ? DEFAULT_MAX_TASKS : cfg_active;
    if (cmd == CMD_LOAD) begin
      slot = d[2:0];
      t_budget[slot] = d[18:3];
      t_left[slot]   = d[18:3];
      t_due[slot]    = {16'd0, d[34:19]};
      t_every[slot]  = d[50:35];
      t_done[slot]   = '0;
    end else if (!sched_halted) begin
      all_done = 1'b1;
      for (int i = 0; i < live; i++) if (t_done[i] < cfg_need) all_done = 1'b0;
      if (sched_clock >= cfg_horizon || all_done) begin
        sched_halted = 1'b1;
      end else begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < live; i++) begin
          if (t_left[i] != 0 && {1'b0, sched_clock} + 33'd1 <= {1'b0, t_due[i]} &&
              (!found || t_due[i] < t_due[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        if (found) begin
          t_left[best] = t_left[best] - 1'b1;
          r.ran = 1'b1;
          r.who = TASK_INDEX_W'(best);
        end
        sched_clock = sched_clock + 1'b1;
        for (int i = 0; i < live; i++) begin
          if (sched_clock >= t_due[i]) begin
            if (t_left[i] != 0) r.missed[i] = 1'b1;
            else if (t_done[i] != COUNT_LIMIT) t_done[i] = t_done[i] + 1'b1;
            r.renewed[i] = 1'b1;
            t_due[i] = t_due[i] + {16'd0, t_every[i]};
            t_left[i] = t_budget[i];
          end
        end
      end
    end
    r.now = sched_clock;
    r.fin = sched_halted;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_load(logic [TASK_INDEX_W-1:0] slot, logic [WORK_W-1:0] work,
                                     logic [WORK_W-1:0] due, logic [WORK_W-1:0] every);
    sched_item_t it;
    it.cmd = CMD_LOAD;
    it.data = {5'd0, every, due, work, slot};
    item_q.push_back(it);
  endfunction

  // tick transfers carry random payload that the block must ignore
  function automatic void queue_tick();
    sched_item_t it;
    it.cmd = CMD_TICK;
    it.data = {5'd0, 51'({$urandom, $urandom})};
    item_q.push_back(it);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACTIVE_TASKS: cfg_active = val[ACTIVE_W-1:0];
      REG_HORIZON:      cfg_horizon = val;
      REG_COMPLETIONS:  cfg_need = val[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (item_q.size() != 0 || s_tvalid || predicted_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) @(posedge clk) cycle_cnt++;
    $display("timeout after %0d cycles", cycle_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (accepted_cnt >= 300);
    @(posedge clk);
    hold_out = 1'b1;
    repeat (300) @(posedge clk);
    hold_out = 1'b0;
  end

  always @(negedge clk) begin : feed
    sched_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_fire || !s_tvalid) begin
      if (in_gap != 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (item_q.size() != 0) begin
        it = item_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= it.data;
        if (!quiet && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 12);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drain_side
    if (hold_out) begin
      m_tready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    sched_out_t want;
    sched_out_t got;
    s_fire = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[2:0], m_tdata[34:3], m_tdata[42:35], m_tdata[50:43],
               m_tdata[51]};
        if (predicted_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          check_field("ran_valid", want.ran, got.ran);
          check_field("ran_task", want.who, got.who);
          check_field("time_now", want.now, got.now);
          check_field("missed_mask", want.missed, got.missed);
          check_field("renewed_mask", want.renewed, got.renewed);
          check_field("finished", want.fin, got.fin);
          checked_cnt++;
          ran_cnt += want.ran;
          miss_cnt += $countones(want.missed);
        end
      end
      s_fire = s_tvalid && s_tready;
      if (s_fire) begin
        predicted_q.push_back(edf_step(s_tuser, s_tdata));
        accepted_cnt++;
      end
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] est;
    int unsigned       r;
    int unsigned       pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: ties, never-ready task, extreme fields
    write_reg(REG_ACTIVE_TASKS, {28'($urandom), 4'd3});
    write_reg(REG_HORIZON, '1);
    write_reg(REG_COMPLETIONS, {24'($urandom), 8'd255});
    @(posedge clk);
    queue_load(0, 16'd2, 16'd5, 16'd5);
    queue_load(1, 16'd2, 16'd5, 16'd4);
    queue_load(2, 16'hFFFF, 16'd0, 16'd0);
    queue_load(3, 16'd0, 16'hFFFF, 16'hFFFF);
    queue_load(4, 16'd1, 16'd3, 16'hFFFF);
    queue_load(5, 16'hFFFF, 16'hFFFF, 16'd1);
    queue_load(6, 16'd0, 16'd0, 16'd0);
    queue_load(7, $urandom, $urandom, $urandom);
    repeat (8) queue_tick();
    queue_load(1, 16'd1, 16'd12, 16'd3);
    repeat (6) queue_tick();

    // random phases; each reloads the whole table so counts stay below the stop level
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_ACTIVE_TASKS, {28'($urandom), (p == 0) ? 4'd8 :
                (p == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8))});
      write_reg(REG_HORIZON, (p == 0) ? '1 : {1'b1, 31'($urandom)});
      write_reg(REG_COMPLETIONS, {24'($urandom), 8'($urandom_range(141, 255))});
      @(posedge clk);
      est = sched_clock;
      for (int k = 0; k < DEFAULT_MAX_TASKS; k++)
        queue_load(k, $urandom_range(0, 4), 16'(est + $urandom_range(1, 24)),
                   $urandom_range(0, 24));
      for (int j = 0; j < 140; j++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          queue_tick();
          est++;
        end else if (r < 90) begin
          queue_load($urandom_range(0, 7), $urandom_range(0, 4),
                     16'(est + $urandom_range(1, 24)), $urandom_range(0, 24));
        end else begin
          queue_load($urandom, $urandom, $urandom, $urandom);
        end
      end
    end

    // completion count saturation: task 0 completes every tick, task 1 always misses
    drain();
    @(posedge clk);
    quiet = 1'b1;
    write_reg(REG_ACTIVE_TASKS, {28'($urandom), 4'd2});
    write_reg(REG_COMPLETIONS, {24'($urandom), 8'd255});
    @(posedge clk);
    queue_load(0, 16'd0, 16'd0, 16'd0);
    queue_load(1, 16'hFFFF, 16'd1, 16'd1);
    for (int j = 0; j < 270; j++) begin
      queue_tick();
      if (j % 9 == 0) queue_load($urandom_range(2, 7), $urandom, $urandom, $urandom);
    end

    // one way to stop, then loads and ticks against the stopped scheduler
    drain();
    pick = $urandom_range(0, 3);
    case (pick)
      0: write_reg(REG_ACTIVE_TASKS, {28'($urandom), 4'd1});
      1: write_reg(REG_HORIZON, sched_clock + $urandom_range(1, 10));
      2: write_reg(REG_ACTIVE_TASKS, {28'($urandom), 4'd0});
      default: write_reg(REG_COMPLETIONS, {24'($urandom), 8'd0});
    endcase
    @(posedge clk);
    for (int j = 0; j < 40; j++) begin
      if ($urandom_range(0, 2) == 0) queue_load($urandom, $urandom, $urandom, $urandom);
      else queue_tick();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d results checked (stop case %0d)", accepted_cnt,
             checked_cnt, pick);
    $display("%0d ticks ran a task, %0d deadline misses, clock ended at %0d", ran_cnt,
             miss_cnt, sched_clock);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
